FILE: rtl/sspq_pkg.sv
// sspq_pkg: shared types and codes for the stable sorted priority queue
// holds the entry layout, operation and status codes, and the cell control struct
// no dependencies
package sspq_pkg;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic [15:0] req_time;
    logic [7:0]  pickup;
    logic [7:0]  dropoff;
    logic [7:0]  item_type;
    logic [15:0] time_limit;
  } entry_t;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_INS_DUE = 2'd1,
    FUNC_DEQUEUE = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOT_DUE = 2'd1,
    ST_FULL = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins;
    logic   deq;
    entry_t ent;
  } cell_ctl_t;

endpackage

FILE: rtl/stable_sorted_priority_queue.sv
// stable_sorted_priority_queue: top level, a chain of sspq_cell slots with a count
// and one registered result stage
// depends on sspq_pkg and sspq_cell
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | in_func, in_req_time, in_now_time, in_pickup,
//          |                      | in_dropoff, in_item_type, in_time_limit
//  out     | out_valid / out_stall| out_out_valid, out_out_req_time, out_out_pickup,
//          |                      | out_out_dropoff, out_out_type, out_out_time_limit,
//          |                      | out_occupancy, out_status
//
// one transaction per cycle while in_stall is low: every cell compares its key with the new
// entry in the same cycle, so an insert or dequeue completes when it is accepted; the result
// appears in the output register in the cycle after acceptance.
// in_stall is high only while a result is held and out_stall is high.
// synchronous reset empties the queue by clearing the count; cell contents are
// not cleared and never read while outside the count.
module stable_sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_req_time,
  input  logic [15:0] in_now_time,
  input  logic [7:0]  in_pickup,
  input  logic [7:0]  in_dropoff,
  input  logic [7:0]  in_item_type,
  input  logic [15:0] in_time_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_out_valid,
  output logic [15:0] out_out_req_time,
  output logic [7:0]  out_out_pickup,
  output logic [7:0]  out_out_dropoff,
  output logic [7:0]  out_out_type,
  output logic [15:0] out_out_time_limit,
  output logic [4:0]  out_occupancy,
  output logic [1:0]  out_status
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovalid_r;
  logic             res_vld_r, res_vld_nxt;
  entry_t           res_ent_r, res_ent_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [CNT_W-1:0] res_cnt_r;

  logic      in_go;
  logic      full, empty;
  cell_ctl_t ctl;
  entry_t    new_ent;
  entry_t    cell_ent [DEPTH];
  logic      cell_gt  [DEPTH];
  logic      cell_occ [DEPTH];

  assign in_stall = ovalid_r && out_stall;
  assign in_go    = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign new_ent.req_time   = in_req_time;
  assign new_ent.pickup     = in_pickup;
  assign new_ent.dropoff    = in_dropoff;
  assign new_ent.item_type  = in_item_type;
  assign new_ent.time_limit = in_time_limit;

  always_comb begin
    ctl.ins     = 1'b0;
    ctl.deq     = 1'b0;
    ctl.ent     = new_ent;
    count_nxt   = count_r;
    res_vld_nxt = 1'b0;
    res_ent_nxt = '0;
    res_st_nxt  = ST_OK;
    unique case (func_t'(in_func))
      FUNC_INSERT: begin
        if (full) begin
          res_st_nxt = ST_FULL;
        end else begin
          ctl.ins = in_go;
        end
      end
      FUNC_INS_DUE: begin
        // due check wins over the full check
        if (in_req_time > in_now_time) begin
          res_st_nxt = ST_NOT_DUE;
        end else if (full) begin
          res_st_nxt = ST_FULL;
        end else begin
          ctl.ins = in_go;
        end
      end
      FUNC_DEQUEUE: begin
        if (empty) begin
          res_st_nxt = ST_EMPTY;
        end else begin
          ctl.deq     = in_go;
          res_vld_nxt = 1'b1;
          res_ent_nxt = cell_ent[0];
        end
      end
      FUNC_NOP: begin
        res_st_nxt = ST_OK;
      end
      default: begin
        res_st_nxt = ST_OK;
      end
    endcase
    if (ctl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.deq) begin
      count_nxt = count_r - 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (count_r > CNT_W'(i));
      if (i == 0) begin : g_head
        sspq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (1'b1),
          .left_gt   (1'b0),
          .left_ent  (new_ent),
          .right_ent (cell_ent[i+1]),
          .gt        (cell_gt[i]),
          .ent       (cell_ent[i])
        );
      end else if (i == DEPTH - 1) begin : g_tail
        sspq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (cell_occ[i-1]),
          .left_gt   (cell_gt[i-1]),
          .left_ent  (cell_ent[i-1]),
          .right_ent (cell_ent[i]),
          .gt        (cell_gt[i]),
          .ent       (cell_ent[i])
        );
      end else begin : g_mid
        sspq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (cell_occ[i]),
          .left_occ  (cell_occ[i-1]),
          .left_gt   (cell_gt[i-1]),
          .left_ent  (cell_ent[i-1]),
          .right_ent (cell_ent[i+1]),
          .gt        (cell_gt[i]),
          .ent       (cell_ent[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_go) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      res_vld_r <= res_vld_nxt;
      res_ent_r <= res_ent_nxt;
      res_st_r  <= res_st_nxt;
      res_cnt_r <= count_nxt;
    end
  end

  logic [CNT_W+OCC_W-1:0] occ_ext;
  assign occ_ext = {{OCC_W{1'b0}}, res_cnt_r};

  assign out_valid          = ovalid_r;
  assign out_out_valid      = res_vld_r;
  assign out_out_req_time   = res_ent_r.req_time;
  assign out_out_pickup     = res_ent_r.pickup;
  assign out_out_dropoff    = res_ent_r.dropoff;
  assign out_out_type       = res_ent_r.item_type;
  assign out_out_time_limit = res_ent_r.time_limit;
  assign out_occupancy      = occ_ext[OCC_W-1:0];
  assign out_status         = res_st_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.deq |=> count_r == $past(count_r) - 1'b1)
    else $error("dequeue did not lower the count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && full && func_t'(in_func) == FUNC_INSERT) |=>
      (out_status == ST_FULL && out_valid && !out_out_valid))
    else $error("insert on full queue not reported as dropped");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_ent[0].req_time <= cell_ent[1].req_time))
    else $error("head of queue out of order");

endmodule

FILE: rtl/sspq_cell.sv
// sspq_cell: one slot of the sorted chain
// holds one entry; on insert it shifts right or takes the new entry, on dequeue shifts left
// depends on sspq_pkg
module sspq_cell (
  input  logic               clk,
  input  sspq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_occ,
  input  logic               left_gt,
  input  sspq_pkg::entry_t   left_ent,
  input  sspq_pkg::entry_t   right_ent,
  output logic               gt,
  output sspq_pkg::entry_t   ent
);
  import sspq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // held entry sorts after the new one; equal keys stay in front
  assign gt = occ && (ent_r.req_time > ctl.ent.req_time);

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (left_gt) begin
        ent_nxt = left_ent;
      end else if (gt || (!occ && left_occ)) begin
        ent_nxt = ctl.ent;
      end
    end else if (ctl.deq) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule
